### hdl/bptb_pkg.sv
`default_nettype none
package bptb_pkg;

  localparam int MODE_W     = 2;
  localparam int KEY_W      = 64;
  localparam int VAL_W      = 64;
  localparam int STAT_W     = 2;
  localparam int NODE_OUT_W = 12;
  localparam int SLOT_OUT_W = 4;
  localparam int KIND_W     = 2;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [KIND_W-1:0] kind_t;

  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_FINISH = 2'd1;
  localparam mode_t MODE_FIND   = 2'd2;
  localparam mode_t MODE_CLEAR  = 2'd3;

  localparam status_t STAT_DONE      = 2'd0;
  localparam status_t STAT_FOUND     = 2'd1;
  localparam status_t STAT_NOT_FOUND = 2'd2;
  localparam status_t STAT_FULL      = 2'd3;

  localparam kind_t KIND_LEAF  = 2'd1;
  localparam kind_t KIND_INNER = 2'd2;

endpackage
`default_nettype wire

### hdl/bptb_in_if.sv
`default_nettype none
interface bptb_in_if import bptb_pkg::*; ();
  logic              valid;
  logic              ready;
  mode_t             mode;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  value;

  modport source (output valid, output mode, output key, output value, input ready);
  modport sink   (input valid, input mode, input key, input value, output ready);
endinterface
`default_nettype wire

### hdl/bptb_out_if.sv
`default_nettype none
interface bptb_out_if import bptb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  status_t               status;
  logic [NODE_OUT_W-1:0] leaf_node;
  logic [SLOT_OUT_W-1:0] slot;
  logic [KEY_W-1:0]      found_key;
  logic [VAL_W-1:0]      found_value;

  modport source (output valid, output status, output leaf_node, output slot,
                  output found_key, output found_value, input ready);
  modport sink   (input valid, input status, input leaf_node, input slot,
                  input found_key, input found_value, output ready);
endinterface
`default_nettype wire

### hdl/bplus_tree_bulk_load_search.sv
// Clear resets the level pointers; insert writes one node per level touched; finish walks up to the top level.
// Find visits one node per level with a binary search over that node's keys, and reads
// the value on a leaf hit; each node costs one node-memory read and serial key reads.
// One word in flight; the next word is taken once the result is registered.
// Reset: synchronous active-low rst_n clears control state and gives an empty tree;
// the node, key, value and child memories are not swept.
`default_nettype none
module bplus_tree_bulk_load_search import bptb_pkg::*; #(
  parameter int LEAF_FANOUT  = 16,
  parameter int INNER_FANOUT = 16,
  parameter int NODE_COUNT   = 4096,
  parameter int MAX_LEVELS   = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  bptb_in_if.sink    in_if,
  bptb_out_if.source out_if
);

  localparam int SLOTS   = (LEAF_FANOUT > INNER_FANOUT) ? LEAF_FANOUT : INNER_FANOUT;
  localparam int ID_W    = $clog2(NODE_COUNT);
  localparam int USED_W  = $clog2(NODE_COUNT + 1);
  localparam int USED_XW = USED_W + 1;
  localparam int FILL_W  = $clog2(SLOTS + 1);
  localparam int LVL_W   = $clog2(MAX_LEVELS);
  localparam int STEP_W  = $clog2(MAX_LEVELS + 2);
  localparam int NEED_W  = $clog2(MAX_LEVELS + 1);
  localparam int DEPTH   = NODE_COUNT * SLOTS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int NODE_W  = KIND_W + FILL_W + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INS   = 4'd1;
  localparam logic [3:0] S_FIN   = 4'd2;
  localparam logic [3:0] S_NODE  = 4'd3;
  localparam logic [3:0] S_HDR   = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_CHILD = 4'd7;
  localparam logic [3:0] S_LEAF  = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [NODE_W-1:0] node_mem  [NODE_COUNT];
  logic [KEY_W-1:0]  key_mem   [DEPTH];
  logic [VAL_W-1:0]  val_mem   [DEPTH];
  logic [ID_W-1:0]   child_mem [DEPTH];

  logic [NODE_W-1:0] node_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic [ID_W-1:0]   child_q;

  logic [3:0]        state_r, state_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [ID_W-1:0]   carry_r, carry_nxt;
  logic [LVL_W-1:0]  top_r, top_nxt;
  logic [ID_W-1:0]   root_r, root_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic [ID_W-1:0]   open_r [MAX_LEVELS];
  logic [ID_W-1:0]   open_nxt [MAX_LEVELS];
  logic [FILL_W-1:0] ofill_r [MAX_LEVELS];
  logic [FILL_W-1:0] ofill_nxt [MAX_LEVELS];
  logic [ID_W-1:0]   cur_r, cur_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [FILL_W-1:0] lo_r, lo_nxt, len_r, len_nxt, fill_r, fill_nxt;
  kind_t             kind_r, kind_nxt;
  logic              tail_r, tail_nxt;

  status_t                res_stat_r, res_stat_nxt;
  logic [NODE_OUT_W-1:0]  res_node_r, res_node_nxt;
  logic [SLOT_OUT_W-1:0]  res_slot_r, res_slot_nxt;
  logic [KEY_W-1:0]       res_key_r, res_key_nxt;
  logic [VAL_W-1:0]       res_val_r, res_val_nxt;

  logic                   out_valid_r, out_valid_nxt;
  status_t                out_stat_r, out_stat_nxt;
  logic [NODE_OUT_W-1:0]  out_node_r, out_node_nxt;
  logic [SLOT_OUT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [KEY_W-1:0]       out_key_r, out_key_nxt;
  logic [VAL_W-1:0]       out_val_r, out_val_nxt;

  logic              node_we, key_we, val_we, child_we;
  logic [ID_W-1:0]   node_wa;
  logic [NODE_W-1:0] node_wd;
  logic [ADDR_W-1:0] slot_wa, find_a;
  logic [ID_W-1:0]   child_wd;

  logic [NEED_W-1:0] need;
  logic              srch, ovf, ins_err;
  logic [ID_W-1:0]   ins_cur, ins_node;
  logic              ins_new, ins_leaf, ins_full;
  logic [FILL_W-1:0] ins_fill, ins_fill1;
  logic              fin_hit;
  logic [LVL_W-1:0]  fin_pl;
  logic [FILL_W-1:0] probe, half;
  logic              in_acc;

  assign in_acc       = in_if.valid && in_if.ready;
  assign in_if.ready  = (state_r == S_IDLE);
  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_stat_r;
  assign out_if.leaf_node   = out_node_r;
  assign out_if.slot        = out_slot_r;
  assign out_if.found_key   = out_key_r;
  assign out_if.found_value = out_val_r;

  assign half   = len_r >> 1;
  assign probe  = lo_r + half;
  assign find_a = ADDR_W'(cur_r) * ADDR_W'(SLOTS) + ADDR_W'(probe);

  always_comb begin
    need = '0;
    if (open_r[0] == '0) begin
      need = NEED_W'(1);
    end
    srch = (ofill_r[0] == FILL_W'(LEAF_FANOUT - 1));
    for (int l = 1; l < MAX_LEVELS; l++) begin
      if (srch) begin
        if (open_r[l] == '0) begin
          need = need + 1'b1;
        end
        if (ofill_r[l] != FILL_W'(INNER_FANOUT - 1)) begin
          srch = 1'b0;
        end
      end
    end
    ovf = (USED_XW'(used_r) + USED_XW'(need)) > USED_XW'(NODE_COUNT);
    ins_err = srch || ovf;
  end

  always_comb begin
    ins_cur   = open_r[lvl_r];
    ins_new   = (ins_cur == '0);
    ins_node  = ins_new ? ID_W'(used_r) : ins_cur;
    ins_fill  = ofill_r[lvl_r];
    ins_fill1 = ins_fill + 1'b1;
    ins_leaf  = (lvl_r == '0);
    ins_full  = ins_leaf ? (ins_fill1 == FILL_W'(LEAF_FANOUT))
                         : (ins_fill1 == FILL_W'(INNER_FANOUT));
  end

  always_comb begin
    fin_hit = 1'b0;
    fin_pl  = '0;
    for (int j = MAX_LEVELS - 1; j >= 0; j--) begin
      if (LVL_W'(j) > lvl_r && LVL_W'(j) <= top_r && open_r[j] != '0) begin
        fin_hit = 1'b1;
        fin_pl  = LVL_W'(j);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    lvl_nxt   = lvl_r;
    carry_nxt = carry_r;
    top_nxt   = top_r;
    root_nxt  = root_r;
    used_nxt  = used_r;
    open_nxt  = open_r;
    ofill_nxt = ofill_r;
    cur_nxt   = cur_r;
    steps_nxt = steps_r;
    lo_nxt    = lo_r;
    len_nxt   = len_r;
    fill_nxt  = fill_r;
    kind_nxt  = kind_r;
    tail_nxt  = tail_r;
    res_stat_nxt = res_stat_r;
    res_node_nxt = res_node_r;
    res_slot_nxt = res_slot_r;
    res_key_nxt  = res_key_r;
    res_val_nxt  = res_val_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_stat_nxt  = out_stat_r;
    out_node_nxt  = out_node_r;
    out_slot_nxt  = out_slot_r;
    out_key_nxt   = out_key_r;
    out_val_nxt   = out_val_r;
    node_we  = 1'b0;
    node_wa  = ins_node;
    node_wd  = '0;
    key_we   = 1'b0;
    val_we   = 1'b0;
    child_we = 1'b0;
    slot_wa  = ADDR_W'(ins_node) * ADDR_W'(SLOTS) + ADDR_W'(ins_fill);
    child_wd = carry_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          key_nxt      = in_if.key;
          val_nxt      = in_if.value;
          lvl_nxt      = '0;
          res_stat_nxt = STAT_DONE;
          res_node_nxt = '0;
          res_slot_nxt = '0;
          res_key_nxt  = '0;
          res_val_nxt  = '0;
          unique case (in_if.mode)
            MODE_INSERT: begin
              if (ins_err) begin
                res_stat_nxt = STAT_FULL;
                state_nxt    = S_EMIT;
              end else begin
                state_nxt = S_INS;
              end
            end
            MODE_FINISH: state_nxt = S_FIN;
            MODE_FIND: begin
              cur_nxt   = root_r;
              steps_nxt = '0;
              state_nxt = S_NODE;
            end
            MODE_CLEAR: begin
              for (int l = 0; l < MAX_LEVELS; l++) begin
                open_nxt[l]  = '0;
                ofill_nxt[l] = '0;
              end
              top_nxt   = '0;
              root_nxt  = '0;
              used_nxt  = USED_W'(1);
              state_nxt = S_EMIT;
            end
            default: state_nxt = S_EMIT;
          endcase
        end
      end
      S_INS: begin
        node_we = 1'b1;
        node_wd = {ins_leaf ? KIND_LEAF : KIND_INNER, ins_fill1, 1'b0};
        key_we  = 1'b1;
        val_we  = ins_leaf;
        child_we = !ins_leaf;
        if (ins_new) begin
          used_nxt = used_r + 1'b1;
        end
        if (!ins_leaf && lvl_r > top_r) begin
          top_nxt = lvl_r;
        end
        open_nxt[lvl_r]  = ins_node;
        ofill_nxt[lvl_r] = ins_fill1;
        if (!ins_leaf) begin
          open_nxt[lvl_r - 1'b1]  = '0;
          ofill_nxt[lvl_r - 1'b1] = '0;
        end
        if (ins_full) begin
          carry_nxt = ins_node;
          lvl_nxt   = lvl_r + 1'b1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_FIN: begin
        if (lvl_r < top_r) begin
          if (open_r[lvl_r] != '0 && fin_hit) begin
            node_we  = 1'b1;
            node_wa  = open_r[fin_pl];
            node_wd  = {KIND_INNER, ofill_r[fin_pl], 1'b1};
            child_we = 1'b1;
            slot_wa  = ADDR_W'(open_r[fin_pl]) * ADDR_W'(SLOTS) + ADDR_W'(ofill_r[fin_pl]);
            child_wd = open_r[lvl_r];
          end
          lvl_nxt = lvl_r + 1'b1;
        end else begin
          root_nxt  = open_r[top_r];
          state_nxt = S_EMIT;
        end
      end
      S_NODE: begin
        if (cur_r == '0 || steps_r > STEP_W'(MAX_LEVELS)) begin
          res_stat_nxt = STAT_NOT_FOUND;
          state_nxt    = S_EMIT;
        end else begin
          state_nxt = S_HDR;
        end
      end
      S_HDR: begin
        kind_nxt  = node_q[NODE_W-1 -: KIND_W];
        fill_nxt  = node_q[FILL_W:1];
        tail_nxt  = node_q[0];
        lo_nxt    = '0;
        len_nxt   = node_q[FILL_W:1];
        state_nxt = S_RD;
      end
      S_RD: begin
        if (len_r != '0) begin
          state_nxt = S_CMP;
        end else begin
          res_stat_nxt = STAT_NOT_FOUND;
          state_nxt    = S_EMIT;
          if (kind_r == KIND_INNER) begin
            if (lo_r < FILL_W'(INNER_FANOUT) &&
                (lo_r < fill_r || (lo_r == fill_r && tail_r))) begin
              state_nxt = S_CHILD;
            end
          end else if (kind_r == KIND_LEAF) begin
            if (lo_r < fill_r) begin
              state_nxt = S_LEAF;
            end
          end
        end
      end
      S_CMP: begin
        if (key_q < key_r) begin
          lo_nxt  = probe + 1'b1;
          len_nxt = len_r - half - 1'b1;
        end else begin
          len_nxt = half;
        end
        state_nxt = S_RD;
      end
      S_CHILD: begin
        cur_nxt   = child_q;
        steps_nxt = steps_r + 1'b1;
        state_nxt = S_NODE;
      end
      S_LEAF: begin
        res_stat_nxt = STAT_FOUND;
        res_node_nxt = NODE_OUT_W'(cur_r);
        res_slot_nxt = SLOT_OUT_W'(lo_r);
        res_key_nxt  = key_q;
        res_val_nxt  = val_q;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_node_nxt  = res_node_r;
          out_slot_nxt  = res_slot_r;
          out_key_nxt   = res_key_r;
          out_val_nxt   = res_val_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    node_q <= node_mem[cur_r];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[slot_wa] <= key_r;
    end
    key_q <= key_mem[find_a];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[slot_wa] <= val_r;
    end
    val_q <= val_mem[find_a];
  end

  always_ff @(posedge clk) begin
    if (child_we) begin
      child_mem[slot_wa] <= child_wd;
    end
    child_q <= child_mem[find_a];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lvl_r       <= '0;
      top_r       <= '0;
      root_r      <= '0;
      used_r      <= USED_W'(1);
      for (int l = 0; l < MAX_LEVELS; l++) begin
        open_r[l]  <= '0;
        ofill_r[l] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      lvl_r       <= lvl_nxt;
      top_r       <= top_nxt;
      root_r      <= root_nxt;
      used_r      <= used_nxt;
      open_r      <= open_nxt;
      ofill_r     <= ofill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    carry_r    <= carry_nxt;
    cur_r      <= cur_nxt;
    steps_r    <= steps_nxt;
    lo_r       <= lo_nxt;
    len_r      <= len_nxt;
    fill_r     <= fill_nxt;
    kind_r     <= kind_nxt;
    tail_r     <= tail_nxt;
    res_stat_r <= res_stat_nxt;
    res_node_r <= res_node_nxt;
    res_slot_r <= res_slot_nxt;
    res_key_r  <= res_key_nxt;
    res_val_r  <= res_val_nxt;
    out_stat_r <= out_stat_nxt;
    out_node_r <= out_node_nxt;
    out_slot_r <= out_slot_nxt;
    out_key_r  <= out_key_nxt;
    out_val_r  <= out_val_nxt;
  end

`ifndef ASSERT_OFF
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    USED_XW'(used_r) <= USED_XW'(NODE_COUNT))
    else $error("node pool count beyond capacity");

  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_valid_r && !out_if.ready) |=> (state_r == S_EMIT))
    else $error("result overwrote an untaken word");

  a_clear_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_if.mode == MODE_CLEAR) |=> (used_r == USED_W'(1) && root_r == '0))
    else $error("clear left tree state");

  a_leaf_fill: assert property (@(posedge clk) disable iff (!rst_n)
    ofill_r[0] <= FILL_W'(LEAF_FANOUT))
    else $error("open leaf overfilled");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && (!out_valid_r || out_if.ready)) |=> (out_valid_r && in_if.ready))
    else $error("result not delivered");
`endif

endmodule
`default_nettype wire

### dv/bptb_tree_checker.sv
`timescale 1ns / 1ps
module bptb_tree_checker import bptb_pkg::*; #(
  parameter int LEAF_FANOUT  = 16,
  parameter int INNER_FANOUT = 16,
  parameter int NODE_COUNT   = 4096,
  parameter int MAX_LEVELS   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  bptb_in_if.sink     in_mon,
  bptb_out_if.sink    out_mon,
  output int          fail_count,
  output int          pending
);
  localparam int SLOTS = (LEAF_FANOUT > INNER_FANOUT) ? LEAF_FANOUT : INNER_FANOUT;

  typedef struct packed {
    status_t               status;
    logic [NODE_OUT_W-1:0] leaf_node;
    logic [SLOT_OUT_W-1:0] slot;
    logic [KEY_W-1:0]      found_key;
    logic [VAL_W-1:0]      found_value;
  } answer_t;

  kind_t            kind_mem [NODE_COUNT];
  int               fill_mem [NODE_COUNT];
  logic [KEY_W-1:0] key_mem  [NODE_COUNT*SLOTS];
  logic [VAL_W-1:0] val_mem  [NODE_COUNT*SLOTS];
  int               child_mem[NODE_COUNT*SLOTS];
  int               open_at  [MAX_LEVELS];
  int               prev_leaf, top_lvl, root_id, used;

  answer_t expected_answers[$];

  function automatic void tree_clear();
    foreach (kind_mem[i]) begin
      kind_mem[i] = '0;
      fill_mem[i] = 0;
    end
    foreach (child_mem[i]) begin
      key_mem[i] = '0;
      val_mem[i] = '0;
      child_mem[i] = 0;
    end
    foreach (open_at[i]) open_at[i] = 0;
    prev_leaf = 0;
    top_lvl = 0;
    root_id = 0;
    used = 1;
  endfunction

  function automatic int grab_node(kind_t k);
    int id;
    id = used;
    used++;
    kind_mem[id] = k;
    fill_mem[id] = 0;
    for (int s = 0; s < SLOTS; s++) child_mem[id*SLOTS+s] = 0;
    return id;
  endfunction

  function automatic bit tree_insert(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    int need, f, lf, n, lvl;
    need = (open_at[0] == 0);
    f = open_at[0] ? fill_mem[open_at[0]] : 0;
    if (f + 1 >= LEAF_FANOUT) begin
      lvl = 1;
      forever begin
        if (lvl >= MAX_LEVELS) return 0;
        if (open_at[lvl] == 0) need++;
        f = open_at[lvl] ? fill_mem[open_at[lvl]] : 0;
        if (f + 1 < INNER_FANOUT) break;
        lvl++;
      end
    end
    if (used + need > NODE_COUNT) return 0;
    if (open_at[0] == 0) open_at[0] = grab_node(KIND_LEAF);
    lf = open_at[0];
    f = fill_mem[lf];
    key_mem[lf*SLOTS+f] = k;
    val_mem[lf*SLOTS+f] = v;
    fill_mem[lf] = f + 1;
    if (f + 1 < LEAF_FANOUT) return 1;
    for (lvl = 1; lvl < MAX_LEVELS; lvl++) begin
      if (open_at[lvl] == 0) begin
        open_at[lvl] = grab_node(KIND_INNER);
        if (lvl > top_lvl) top_lvl = lvl;
      end
      n = open_at[lvl];
      f = fill_mem[n];
      key_mem[n*SLOTS+f] = k;
      child_mem[n*SLOTS+f] = open_at[lvl-1];
      fill_mem[n] = f + 1;
      open_at[lvl-1] = 0;
      if (f + 1 < INNER_FANOUT) break;
    end
    prev_leaf = lf;
    return 1;
  endfunction

  function automatic void tree_finish();
    int p;
    for (int i = 0; i < top_lvl && i < MAX_LEVELS; i++) begin
      if (open_at[i] != 0) begin
        for (int j = i + 1; j <= top_lvl && j < MAX_LEVELS; j++) begin
          p = open_at[j];
          if (p != 0) begin
            if (fill_mem[p] < SLOTS) child_mem[p*SLOTS+fill_mem[p]] = open_at[i];
            break;
          end
        end
      end
    end
    root_id = (top_lvl < MAX_LEVELS) ? open_at[top_lvl] : 0;
  endfunction

  function automatic answer_t tree_find(logic [KEY_W-1:0] needle);
    answer_t a;
    int n, lo, len, half, fl;
    a = '0;
    a.status = STAT_NOT_FOUND;
    n = root_id;
    for (int step = 0; step <= MAX_LEVELS; step++) begin
      if (n == 0 || n >= NODE_COUNT) return a;
      fl = fill_mem[n];
      len = (fl > SLOTS) ? SLOTS : fl;
      lo = 0;
      while (len > 0) begin
        half = len >> 1;
        if (key_mem[n*SLOTS+lo+half] < needle) begin
          lo = lo + half + 1;
          len = len - half - 1;
        end else len = half;
      end
      if (kind_mem[n] == KIND_INNER) begin
        n = (lo < INNER_FANOUT) ? child_mem[n*SLOTS+lo] : 0;
      end else if (kind_mem[n] == KIND_LEAF) begin
        if (lo < fl && lo < SLOTS) begin
          a.status = STAT_FOUND;
          a.leaf_node = n[NODE_OUT_W-1:0];
          a.slot = lo[SLOT_OUT_W-1:0];
          a.found_key = key_mem[n*SLOTS+lo];
          a.found_value = val_mem[n*SLOTS+lo];
        end
        return a;
      end else return a;
    end
    return a;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    tree_clear();
  end

  always @(posedge clk) begin
    answer_t a, got, want;
    if (rst_n && in_mon.valid && in_mon.ready) begin
      a = '0;
      case (in_mon.mode)
        MODE_INSERT: if (!tree_insert(in_mon.key, in_mon.value)) a.status = STAT_FULL;
        MODE_FINISH: tree_finish();
        MODE_FIND:   a = tree_find(in_mon.key);
        default:     tree_clear();
      endcase
      expected_answers.push_back(a);
    end
    if (rst_n && out_mon.valid && out_mon.ready) begin
      got = {out_mon.status, out_mon.leaf_node, out_mon.slot,
             out_mon.found_key, out_mon.found_value};
      if (expected_answers.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected word: %p", got);
      end else begin
        want = expected_answers.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
    pending = expected_answers.size();
  end
endmodule

### dv/bplus_tree_bulk_load_search_test.sv
`timescale 1ns / 1ps
module bplus_tree_bulk_load_search_test;
  import bptb_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count, pending, idle_cycles;
  bit   send_gaps = 1, sink_gaps = 1, hold_off = 0;
  logic [KEY_W-1:0] next_key;
  logic [KEY_W-1:0] built_keys[$];

  bptb_in_if  in_if ();
  bptb_out_if out_if ();

  bplus_tree_bulk_load_search dut (.clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if));

  bptb_tree_checker checker_i (.clk(clk), .rst_n(rst_n), .in_mon(in_if), .out_mon(out_if),
                               .fail_count(fail_count), .pending(pending));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    in_if.valid = 0;
    in_if.mode = MODE_INSERT;
    in_if.key = '0;
    in_if.value = '0;
    out_if.ready = 0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_if.ready <= 0;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end else if (sink_gaps && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 0;
        n = $urandom_range(1, 18);
        repeat (n - 1) @(negedge clk);
      end else out_if.ready <= 1;
    end
  end

  task automatic send(mode_t m, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    if (send_gaps && $urandom_range(0, 9) == 0) begin
      in_if.valid <= 0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_if.valid <= 1;
    in_if.mode <= m;
    in_if.key <= k;
    in_if.value <= v;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic drain();
    in_if.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic build_tree(int count, bit dense);
    built_keys.delete();
    send(MODE_CLEAR, rand64(), rand64());
    next_key = dense ? 64'd0 : {8'h0, $urandom_range(0, 255), 24'h0};
    for (int i = 0; i < count; i++) begin
      next_key += dense ? 64'd2 : 64'($urandom_range(1, 1 << 20));
      built_keys.push_back(next_key);
      send(MODE_INSERT, next_key, rand64());
    end
    send(MODE_FINISH, rand64(), rand64());
  endtask

  task automatic probe_tree(int count);
    logic [KEY_W-1:0] k;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 9);
      if (built_keys.size() == 0 || sel == 0) k = rand64();
      else begin
        k = built_keys[$urandom_range(0, built_keys.size() - 1)];
        if (sel < 3) k = k - 1;
        else if (sel == 3) k = k + 1;
      end
      send(MODE_FIND, k, rand64());
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    send(MODE_FIND, 64'd5, '0);
    send(MODE_FINISH, '0, '0);
    send(MODE_FIND, '0, '0);
    send(MODE_INSERT, '0, '0);
    send(MODE_INSERT, 64'd100, '1);
    send(MODE_INSERT, '1, 64'h5555_aaaa_5555_aaaa);
    send(MODE_FINISH, '0, '0);
    send(MODE_FIND, '0, '0);
    send(MODE_FIND, 64'd50, '0);
    send(MODE_FIND, '1, '0);
    send(MODE_FIND, 64'hffff_ffff_ffff_fffe, '0);
    drain();
    build_tree(16, 1);
    send(MODE_FIND, 64'd32, '0);
    send(MODE_FIND, 64'd33, '0);
    send(MODE_FIND, 64'd1, '0);
    send(MODE_INSERT, 64'd40, 64'd7);
    send(MODE_FIND, 64'd40, '0);
    send(MODE_FINISH, '0, '0);
    send(MODE_FIND, 64'd40, '0);
    drain();
    hold_off = 1;
    build_tree(40, 0);
    hold_off = 0;
    probe_tree(30);
    drain();
    for (int r = 0; r < 3; r++) begin
      build_tree($urandom_range(0, 60), $urandom_range(0, 1));
      probe_tree(40);
      if ($urandom_range(0, 3) == 0) send(MODE_INSERT, rand64(), rand64());
    end
    build_tree(260, 0);
    send_gaps = 0;
    sink_gaps = 0;
    probe_tree(60);
    drain();
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
